### src/event_timer_table_core_assert.svh
// Assertion macros shared by the timer table RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef EVENT_TIMER_TABLE_CORE_ASSERT_SVH
`define EVENT_TIMER_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define ETMR_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("timer table check failed");
`define ETMR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("timer table check failed");
`else
`define ETMR_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ETMR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### src/etmr_pkg.sv
// Shared codes and types of the timer table.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
package etmr_pkg;
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 48;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] event_bits;
    logic        periodic;
  } req_t;
endpackage

### src/event_timer_table_core.sv
// Top level of the event timer table: front end, request queue, table sequencer.
// Depends on etmr_pkg, etmr_front, etmr_queue and etmr_back.
//
//  channel | direction | tuser          | tdata                                      | tlast
//  in_     | slave     | cmd[1:0]       | task_id, event_bits, periodic, period_ticks | -
//  out_    | master    | kind           | status, fired_task, fired_event             | last
//
// A start or stop word passes through the back end in order: the request is taken
// from the queue (ST_IDLE), every table entry is visited for the match and free-entry
// scan (ST_SCAN), and then the table is updated and the status posted (ST_APPLY).
// A tick with nothing expiring goes from ST_TICK straight back to ST_IDLE. Otherwise
// ST_TICK is followed by a rank pass over every table entry (ST_POS) and then one
// result word per fired timer (ST_EMIT).
// Reset (rst_n low, synchronous) clears the entry valid bits, the queue and the
// result register; no clearing pass is needed.
// A stalled result port holds the sequencer, while the front end keeps accepting
// words until the two-word request queue is full.
`timescale 1ns / 1ps
module event_timer_table_core #(
  parameter int TIMER_ENTRIES = 16,
  parameter int TICK_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  // task_id[7:0], event_bits[39:8], periodic[40], period_ticks[72:41], zero fill
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [0:0]  out_tuser,  // kind
  // status[1:0], fired_task[9:2], fired_event[41:10], zero fill
  output logic [47:0] out_tdata,
  output logic        out_tlast
);
  // Queue word carries the classified request and the clamped period.
  localparam int QW = $bits(etmr_pkg::req_t) + TICK_WIDTH;

  etmr_pkg::req_t        fe_req, be_req;
  logic [TICK_WIDTH-1:0] fe_period, be_period;
  logic                  q_push, q_full, q_pop, q_not_empty;
  logic [QW-1:0]         q_data;

  etmr_front #(
    .TW (TICK_WIDTH)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (fe_req),
    .q_period  (fe_period)
  );

  etmr_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({fe_req, fe_period}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign be_req    = q_data[QW-1:TICK_WIDTH];
  assign be_period = q_data[TICK_WIDTH-1:0];

  etmr_back #(
    .N  (TIMER_ENTRIES),
    .TW (TICK_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_pop      (q_pop),
    .q_req      (be_req),
    .q_period   (be_period),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );
endmodule

### src/etmr_front.sv
// Front end: accepts input words, drops unused commands, clamps the period.
// Depends on etmr_pkg.
`timescale 1ns / 1ps
module etmr_front #(
  parameter int TW = 32
) (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [1:0]                   in_tuser,
  input  logic [etmr_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         q_full,
  output logic                         q_push,
  output etmr_pkg::req_t               q_req,
  output logic [TW-1:0]                q_period
);
  logic [31:0]   raw_period;
  logic [TW-1:0] sat_period;

  assign raw_period = in_tdata[72:41];

  generate
    if (TW > 32) begin : g_wide
      assign sat_period = {{(TW-32){1'b0}}, raw_period};
    end else if (TW == 32) begin : g_equal
      assign sat_period = raw_period;
    end else begin : g_narrow
      assign sat_period = (|raw_period[31:TW]) ? {TW{1'b1}} : raw_period[TW-1:0];
    end
  endgenerate

  // A zero period expires on the next tick.
  assign q_period = (sat_period == '0) ? TW'(1) : sat_period;

  assign q_req.cmd        = in_tuser;
  assign q_req.task_id    = in_tdata[7:0];
  assign q_req.event_bits = in_tdata[39:8];
  assign q_req.periodic   = in_tdata[40];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full &&
                     (in_tuser == etmr_pkg::CMD_TICK || in_tuser == etmr_pkg::CMD_START ||
                      in_tuser == etmr_pkg::CMD_STOP);
endmodule

### src/etmr_queue.sv
// Short request queue between the front end and the table sequencer.
// Depends on etmr_pkg for its depth.
`timescale 1ns / 1ps
module etmr_queue #(
  parameter int DW = 105
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);
  localparam int PW = (etmr_pkg::QUEUE_DEPTH > 1) ? $clog2(etmr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(etmr_pkg::QUEUE_DEPTH + 1);

  logic [DW-1:0] mem [etmr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(etmr_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(etmr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(etmr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end
endmodule

### src/etmr_back.sv
// Back end: timer table, command sequencer and result register.
// Depends on etmr_pkg and event_timer_table_core_assert.svh.
`timescale 1ns / 1ps
`include "event_timer_table_core_assert.svh"
module etmr_back #(
  parameter int N  = 16,
  parameter int TW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  etmr_pkg::req_t                q_req,
  input  logic [TW-1:0]                 q_period,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [0:0]                    out_tuser,
  output logic [etmr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_APPLY = 6'b000100,
    ST_TICK  = 6'b001000,
    ST_POS   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  etmr_pkg::req_t  req_r, req_nxt;
  logic [TW-1:0]   period_r, period_nxt;
  logic [IW-1:0]   idx_r, idx_nxt, k_r, k_nxt;
  logic            hit_r, hit_nxt, free_found_r, free_found_nxt;
  logic [IW-1:0]   hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt;
  logic [N-1:0]    fired_r, fired_nxt;
  logic [IW-1:0]   pos_r [N];
  logic [IW-1:0]   pos_nxt [N];

  logic [N-1:0]    valid_r, valid_nxt;
  logic [7:0]      task_r [N];
  logic [7:0]      task_nxt [N];
  logic [31:0]     event_r [N];
  logic [31:0]     event_nxt [N];
  logic [N-1:0]    reload_r, reload_nxt;
  logic [TW-1:0]   per_r [N];
  logic [TW-1:0]   per_nxt [N];
  logic [TW-1:0]   rem_r [N];
  logic [TW-1:0]   rem_nxt [N];
  logic [IW-1:0]   rec_r [N];
  logic [IW-1:0]   rec_nxt [N];

  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [7:0]      out_task_r, out_task_nxt;
  logic [31:0]     out_event_r, out_event_nxt;

  logic            out_free, scan_match, do_mr, do_free;
  logic [IW-1:0]   tgt, sel_idx, pos_cnt;
  logic [N-1:0]    sel;

  assign out_free = !out_valid_r || out_tready;
  assign scan_match = valid_r[idx_r] && (req_r.task_id != 8'd0) &&
                      (task_r[idx_r] == req_r.task_id) &&
                      (event_r[idx_r] == req_r.event_bits);

  always_comb begin
    sel     = '0;
    sel_idx = '0;
    pos_cnt = '0;
    for (int j = 0; j < N; j++) begin
      sel[j] = fired_r[j] && (pos_r[j] == k_r);
      if (sel[j]) begin
        sel_idx = sel_idx | IW'(j);
      end
      if (fired_r[j] && (rec_r[j] < rec_r[idx_r])) begin
        pos_cnt = pos_cnt + IW'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    period_nxt     = period_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    fired_nxt      = fired_r;
    pos_nxt        = pos_r;
    valid_nxt      = valid_r;
    task_nxt       = task_r;
    event_nxt      = event_r;
    reload_nxt     = reload_r;
    per_nxt        = per_r;
    rem_nxt        = rem_r;
    rec_nxt        = rec_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_status_nxt = out_status_r;
    out_task_nxt   = out_task_r;
    out_event_nxt  = out_event_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    do_mr          = 1'b0;
    do_free        = 1'b0;
    tgt            = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          req_nxt        = q_req;
          period_nxt     = q_period;
          idx_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = (q_req.cmd == etmr_pkg::CMD_TICK) ? ST_TICK : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_match && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (!valid_r[idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(N - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = etmr_pkg::KIND_STATUS;
          out_task_nxt   = 8'd0;
          out_event_nxt  = 32'd0;
          out_last_nxt   = 1'b1;
          out_status_nxt = etmr_pkg::STATUS_OK;
          state_nxt      = ST_IDLE;
          if (req_r.cmd == etmr_pkg::CMD_START) begin
            if (hit_r || free_found_r) begin
              tgt              = hit_r ? hit_idx_r : free_idx_r;
              do_mr            = 1'b1;
              task_nxt[tgt]    = req_r.task_id;
              event_nxt[tgt]   = req_r.event_bits;
              reload_nxt[tgt]  = req_r.periodic;
              per_nxt[tgt]     = period_r;
              rem_nxt[tgt]     = period_r;
            end else begin
              out_status_nxt = etmr_pkg::STATUS_FULL;
            end
          end else if (hit_r) begin
            tgt     = hit_idx_r;
            do_free = 1'b1;
          end else begin
            out_status_nxt = etmr_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      ST_TICK: begin
        for (int j = 0; j < N; j++) begin
          fired_nxt[j] = valid_r[j] && (rem_r[j] == TW'(1));
          if (valid_r[j]) begin
            rem_nxt[j] = rem_r[j] - TW'(1);
          end
        end
        idx_nxt   = '0;
        state_nxt = (fired_nxt == '0) ? ST_IDLE : ST_POS;
      end
      ST_POS: begin
        // Output slot of an entry is the number of fired entries more recent than it.
        pos_nxt[idx_r] = pos_cnt;
        idx_nxt        = idx_r + IW'(1);
        k_nxt          = '0;
        if (idx_r == IW'(N - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = etmr_pkg::KIND_FIRE;
          out_status_nxt = etmr_pkg::STATUS_OK;
          out_task_nxt   = task_r[sel_idx];
          out_event_nxt  = event_r[sel_idx];
          out_last_nxt   = ((fired_r & ~sel) == '0);
          fired_nxt      = fired_r & ~sel;
          k_nxt          = k_r + IW'(1);
          tgt            = sel_idx;
          if (reload_r[sel_idx]) begin
            rem_nxt[sel_idx] = per_r[sel_idx];
            do_mr            = 1'b1;
          end else begin
            do_free = 1'b1;
          end
          if ((fired_r & ~sel) == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Recency ranks move together whenever an entry is restarted or freed.
    for (int j = 0; j < N; j++) begin
      if (IW'(j) != tgt && valid_r[j]) begin
        if (do_mr && (!valid_r[tgt] || rec_r[j] < rec_r[tgt])) begin
          rec_nxt[j] = rec_r[j] + IW'(1);
        end
        if (do_free && rec_r[j] > rec_r[tgt]) begin
          rec_nxt[j] = rec_r[j] - IW'(1);
        end
      end
    end
    if (do_mr) begin
      rec_nxt[tgt]   = '0;
      valid_nxt[tgt] = 1'b1;
    end
    if (do_free) begin
      valid_nxt[tgt] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    period_r     <= period_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    pos_r        <= pos_nxt;
    task_r       <= task_nxt;
    event_r      <= event_nxt;
    reload_r     <= reload_nxt;
    per_r        <= per_nxt;
    rem_r        <= rem_nxt;
    rec_r        <= rec_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_event_r  <= out_event_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'b0, out_event_r, out_task_r, out_status_r};

  `ETMR_ASSERT_IMPLY(a_emit_has_fired, clk, rst_n, state_r == ST_EMIT, fired_r != '0)
  `ETMR_ASSERT_IMPLY(a_emit_one_slot, clk, rst_n, state_r == ST_EMIT, $onehot(sel))
  `ETMR_ASSERT_IMPLY(a_idle_no_fired, clk, rst_n, state_r == ST_IDLE, fired_r == '0)
  `ETMR_ASSERT_NEXT(a_last_to_idle, clk, rst_n,
                    state_r == ST_EMIT && out_free && (fired_r & ~sel) == '0,
                    state_r == ST_IDLE && out_tlast)
endmodule

### dv/testbench.sv
// Self-checking bench for event_timer_table_core: random start, stop and tick words
// are driven in bursts, a built-in table predictor checks every result word in order.
// Depends on etmr_pkg and the event_timer_table_core RTL.
`timescale 1ns / 1ps
module testbench;
  localparam int NENT = 16;
  localparam int LIMIT_CYCLES = 800000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] event_bits;
    logic        periodic;
    logic [31:0] period_ticks;
  } cmd_word_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  fired_task;
    logic [31:0] fired_event;
    logic        last;
  } result_word_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [1:0] in_tuser;
  logic [79:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [0:0] out_tuser;
  logic [47:0] out_tdata;
  logic out_tlast;

  event_timer_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // Predicted table contents.
  bit          tbl_valid[NENT];
  logic [7:0]  tbl_task[NENT];
  logic [31:0] tbl_event[NENT];
  bit          tbl_reload[NENT];
  logic [31:0] tbl_period[NENT];
  logic [31:0] tbl_left[NENT];
  int          tbl_rank[NENT];

  cmd_word_t    pending_words[$];
  result_word_t expected_results[$];
  int mismatches = 0;
  int stimulus_done = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic void promote(int i);
    int old;
    old = tbl_valid[i] ? tbl_rank[i] : 32'h7fffffff;
    for (int j = 0; j < NENT; j++)
      if (j != i && tbl_valid[j] && tbl_rank[j] < old) tbl_rank[j]++;
    tbl_rank[i] = 0;
  endfunction

  function automatic void release_entry(int i);
    for (int j = 0; j < NENT; j++)
      if (j != i && tbl_valid[j] && tbl_rank[j] > tbl_rank[i]) tbl_rank[j]--;
    tbl_valid[i] = 0;
  endfunction

  function automatic int lookup(logic [7:0] t, logic [31:0] e);
    if (t == 0) return -1;
    for (int i = 0; i < NENT; i++)
      if (tbl_valid[i] && tbl_task[i] == t && tbl_event[i] == e) return i;
    return -1;
  endfunction

  function automatic void push_status(logic [1:0] st);
    result_word_t r;
    r = '0;
    r.kind = etmr_pkg::KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted command word to the predicted table.
  function automatic void predict_table(cmd_word_t w);
    logic [31:0] per;
    int m, n;
    bit fired[NENT];
    int order[NENT];
    result_word_t r;
    per = (w.period_ticks == 0) ? 32'd1 : w.period_ticks;
    if (w.cmd == etmr_pkg::CMD_START) begin
      m = lookup(w.task_id, w.event_bits);
      if (m < 0) begin
        for (int i = 0; i < NENT; i++)
          if (!tbl_valid[i]) begin
            m = i;
            break;
          end
        if (m < 0) begin
          push_status(etmr_pkg::STATUS_FULL);
          return;
        end
        tbl_task[m] = w.task_id;
        tbl_event[m] = w.event_bits;
      end
      tbl_reload[m] = w.periodic;
      tbl_period[m] = per;
      tbl_left[m] = per;
      promote(m);
      tbl_valid[m] = 1;
      push_status(etmr_pkg::STATUS_OK);
    end else if (w.cmd == etmr_pkg::CMD_STOP) begin
      m = lookup(w.task_id, w.event_bits);
      if (m < 0) push_status(etmr_pkg::STATUS_NOT_FOUND);
      else begin
        release_entry(m);
        push_status(etmr_pkg::STATUS_OK);
      end
    end else if (w.cmd == etmr_pkg::CMD_TICK) begin
      n = 0;
      for (int i = 0; i < NENT; i++) begin
        fired[i] = 0;
        if (tbl_valid[i]) begin
          tbl_left[i] = tbl_left[i] - 1;
          if (tbl_left[i] == 0) fired[i] = 1;
        end
      end
      for (int rk = 0; rk < NENT; rk++)
        for (int i = 0; i < NENT; i++)
          if (fired[i] && tbl_rank[i] == rk) begin
            order[n++] = i;
            break;
          end
      for (int k = 0; k < n; k++) begin
        r = '0;
        r.kind = etmr_pkg::KIND_FIRE;
        r.fired_task = tbl_task[order[k]];
        r.fired_event = tbl_event[order[k]];
        r.last = (k == n - 1);
        expected_results.push_back(r);
      end
      for (int k = 0; k < n; k++) begin
        if (tbl_reload[order[k]]) begin
          tbl_left[order[k]] = tbl_period[order[k]];
          promote(order[k]);
        end else release_entry(order[k]);
      end
    end
  endfunction

  function automatic cmd_word_t make_word(logic [1:0] c, logic [7:0] t, logic [31:0] e,
                                          logic p, logic [31:0] per);
    cmd_word_t w;
    w.cmd = c;
    w.task_id = t;
    w.event_bits = e;
    w.periodic = p;
    w.period_ticks = per;
    return w;
  endfunction

  // Driver: bursts of words separated by random gaps; the word at the head of
  // the pending queue stays there until it is accepted. Pauses use the hold flag.
  int burst_left = 0, gap_left = 0;
  bit hold_for_drain = 0;
  cmd_word_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser <= '0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_table(cur);
        void'(pending_words.pop_front());
      end
      if (in_tvalid && !in_tready) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (hold_for_drain && (expected_results.size() != 0 || in_tvalid)) begin
        in_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur = pending_words[0];
        in_tvalid <= 1'b1;
        in_tuser <= cur.cmd;
        in_tdata <= {7'd0, cur.period_ticks, cur.periodic, cur.event_bits, cur.task_id};
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver stalls in a pattern of its own: long ready stretches and long stalls.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 600 < 200) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 99) < ((stall_phase % 600 < 400) ? 70 : 20));
    end
  end

  // Monitor: compare each accepted result word with the oldest expectation.
  result_word_t got, exp_r;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser[0];
      got.status = out_tdata[1:0];
      got.fired_task = out_tdata[9:2];
      got.fired_event = out_tdata[41:10];
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d st %0d task %0d ev %h last %0d,",
                     exp_r.kind, exp_r.status, exp_r.fired_task, exp_r.fired_event,
                     exp_r.last,
                     " got kind %0d st %0d task %0d ev %h last %0d",
                     got.kind, got.status, got.fired_task, got.fired_event,
                     got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random word: mostly starts and ticks on a small pool of tasks and events
  // with short periods so timers keep firing; a few wide values and noise.
  function automatic cmd_word_t random_word();
    logic [1:0] c;
    logic [7:0] t;
    logic [31:0] e, per;
    int sel;
    sel = $urandom_range(0, 99);
    c = (sel < 40) ? etmr_pkg::CMD_TICK : (sel < 75) ? etmr_pkg::CMD_START :
        (sel < 97) ? etmr_pkg::CMD_STOP : etmr_pkg::CMD_NONE;
    t = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    e = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 3));
    per = ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 6));
    return make_word(c, t, e, 1'($urandom), per);
  endfunction

  initial begin
    int idle;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: field extremes, each command, zero period, task id 0,
    // unknown command, stop miss, periodic reload, table full.
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 0, 0, 0, 0));
    pending_words.push_back(make_word(etmr_pkg::CMD_STOP, 8'd5, 32'd1, 0, 1));
    pending_words.push_back(make_word(etmr_pkg::CMD_START, 8'hff, 32'hffffffff, 1,
                                      32'hffffffff));
    pending_words.push_back(make_word(etmr_pkg::CMD_START, 8'd0, 32'd7, 0, 32'd0));
    pending_words.push_back(make_word(etmr_pkg::CMD_START, 8'd3, 32'd0, 1, 32'd1));
    pending_words.push_back(make_word(etmr_pkg::CMD_NONE, 8'hff, 32'hffffffff, 1,
                                      32'hffffffff));
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 8'hff, 32'hffffffff, 1,
                                      32'hffffffff));
    pending_words.push_back(make_word(etmr_pkg::CMD_STOP, 8'd0, 32'd7, 0, 1));
    pending_words.push_back(make_word(etmr_pkg::CMD_START, 8'd3, 32'd0, 0, 32'd2));
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 0, 0, 0, 0));
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_word(etmr_pkg::CMD_START, 8'(i + 10), 32'(i),
                                        1'(i % 2), 32'd1));
    pending_words.push_back(make_word(etmr_pkg::CMD_STOP, 8'hff, 32'hffffffff, 0, 1));
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 0, 0, 0, 0));
    pending_words.push_back(make_word(etmr_pkg::CMD_TICK, 0, 0, 0, 0));
    while (pending_words.size() != 0) @(posedge clk);

    // Drain everything before going on.
    hold_for_drain = 1;
    while (expected_results.size() != 0) @(posedge clk);
    hold_for_drain = 0;

    for (int i = 0; i < 380; i++) begin
      pending_words.push_back(random_word());
      if (i == 200) begin
        while (pending_words.size() != 0) @(posedge clk);
        hold_for_drain = 1;
        while (expected_results.size() != 0) @(posedge clk);
        hold_for_drain = 0;
      end
    end
    while (pending_words.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    idle = 0;
    while (idle < 200) begin
      @(posedge clk);
      idle++;
    end
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
